// ===== rtl/negb_pkg.sv =====
// Shared types and constants of the normal elevation ground bin selector.
package negb_pkg;

    // Number of ten-degree elevation bins and the neutral bin of a flat normal.
    localparam int NUM_BINS = 18;
    localparam logic [4:0] CENTER_BIN = 5'd9;
    localparam logic [4:0] NO_GROUND_BIN = 5'd31;

    // Boundaries on one side of the horizontal plane, each with its squared sine.
    localparam int NUM_CMP = 8;
    localparam logic [13:0] SIN2_Q14 [0:NUM_CMP] = '{
        14'd0, 14'd494, 14'd1917, 14'd4096, 14'd6769,
        14'd9615, 14'd12288, 14'd14467, 14'd15890
    };

    // Depth of the queue between classification and bookkeeping.
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    // Configuration register indexes.
    localparam logic REG_EXCL_LO = 1'b0;
    localparam logic REG_EXCL_HI = 1'b1;

    typedef struct packed {
        logic [4:0] bin;
        logic       last;
    } t_negb_qent;

    typedef struct packed {
        logic [31:0] n2;
        logic [45:0] lhs;
        logic        zpos;
        logic        zzero;
        logic        last;
        logic [3:0]  cge;
        logic [3:0]  cle;
    } t_negb_cmp;

    // Magnitude of a signed 16-bit value; the most negative value maps to 32768.
    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic signed [15:0] neg;
        neg = -v;
        return v[15] ? 16'(neg) : 16'(v);
    endfunction

endpackage

// ===== rtl/negb_in_if.sv =====
// Input channel carrying one surface normal per transfer.
interface negb_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic               last_point;

    modport source (output valid, output vec_x, output vec_y, output vec_z,
                    output last_point, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z,
                    input last_point, output ready);
endinterface

// ===== rtl/negb_out_if.sv =====
// Output channel carrying one keep flag per transfer.
interface negb_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] point_index;
    logic       keep;
    logic [4:0] chosen_bin;
    logic [6:0] bin_count;
    logic       last_result;

    modport source (output valid, output point_index, output keep, output chosen_bin,
                    output bin_count, output last_result, input ready);
    modport sink   (input valid, input point_index, input keep, input chosen_bin,
                    input bin_count, input last_result, output ready);
endinterface

// ===== rtl/negb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module negb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/negb_front.sv =====
// Classification pipeline: squares, squared norm and one boundary compare per stage.
module negb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    negb_in_if.sink              i_pt,
    output logic                 o_q_valid,
    output negb_pkg::t_negb_qent o_q_ent,
    input  logic                 i_q_ready
);
    import negb_pkg::*;

    logic        adv;
    logic [15:0] mx, my, mz;
    logic        r_va;
    logic [31:0] r_x2, r_y2, r_z2;
    logic        r_a_zpos, r_a_zzero, r_a_last;
    t_negb_cmp   r_cs [0:NUM_CMP];
    t_negb_cmp   n_cs [0:NUM_CMP];
    logic [NUM_CMP:0] r_cv;
    t_negb_cmp   tail;

    // The whole pipeline moves together; it holds only when its tail cannot drain.
    assign adv = !r_cv[NUM_CMP] || i_q_ready;
    assign i_pt.ready = adv;

    assign mx = mag16(i_pt.vec_x);
    assign my = mag16(i_pt.vec_y);
    assign mz = mag16(i_pt.vec_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_cv <= '0;
        end else if (adv) begin
            r_va <= i_pt.valid;
            r_cv <= {r_cv[NUM_CMP-1:0], r_va};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x2      <= 32'(mx) * 32'(mx);
            r_y2      <= 32'(my) * 32'(my);
            r_z2      <= 32'(mz) * 32'(mz);
            r_a_zpos  <= !i_pt.vec_z[15] && (i_pt.vec_z != 16'sd0);
            r_a_zzero <= (i_pt.vec_z == 16'sd0);
            r_a_last  <= i_pt.last_point;
            for (int j = 0; j <= NUM_CMP; j++) begin
                r_cs[j] <= n_cs[j];
            end
        end
    end

    // Stage zero forms the squared norm and the scaled z term; each later stage
    // tests one boundary pair (above and below the horizontal plane).
    always_comb begin
        logic [45:0] prod;
        n_cs[0].n2    = r_x2 + r_y2 + r_z2;
        n_cs[0].lhs   = {r_z2, 14'd0};
        n_cs[0].zpos  = r_a_zpos;
        n_cs[0].zzero = r_a_zzero;
        n_cs[0].last  = r_a_last;
        n_cs[0].cge   = 4'd0;
        n_cs[0].cle   = 4'd0;
        for (int j = 1; j <= NUM_CMP; j++) begin
            prod = 46'(r_cs[j-1].n2) * 46'(SIN2_Q14[j]);
            n_cs[j] = r_cs[j-1];
            n_cs[j].cge = r_cs[j-1].cge + 4'(r_cs[j-1].lhs >= prod);
            n_cs[j].cle = r_cs[j-1].cle + 4'(r_cs[j-1].lhs <= prod);
        end
    end

    assign tail = r_cs[NUM_CMP];
    assign o_q_valid = r_cv[NUM_CMP];
    assign o_q_ent.last = tail.last;

    // Upward normals count boundaries passed above the plane, downward ones
    // count those below it, and a flat normal sits in the center bin.
    always_comb begin
        if (tail.zpos) begin
            o_q_ent.bin = CENTER_BIN + {1'b0, tail.cge};
        end else if (tail.zzero) begin
            o_q_ent.bin = CENTER_BIN;
        end else begin
            o_q_ent.bin = {1'b0, tail.cle};
        end
    end
endmodule

// ===== rtl/negb_fifo.sv =====
// Short queue of classified points between the front and back parts.
module negb_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_valid,
    input  negb_pkg::t_negb_qent i_wr_ent,
    output logic                 o_wr_ready,
    output logic                 o_rd_valid,
    output negb_pkg::t_negb_qent o_rd_ent,
    input  logic                 i_rd_ready
);
    import negb_pkg::*;

    t_negb_qent     r_mem [QDEPTH];
    logic [QAW:0]   r_wp, r_rp;
    logic           full, empty, wr, rd;

    assign empty = (r_wp == r_rp);
    assign full  = (r_wp[QAW] != r_rp[QAW]) && (r_wp[QAW-1:0] == r_rp[QAW-1:0]);
    assign o_wr_ready = !full;
    assign o_rd_valid = !empty;
    assign o_rd_ent   = r_mem[r_rp[QAW-1:0]];
    assign wr = i_wr_valid && !full;
    assign rd = i_rd_ready && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp[QAW-1:0]] <= i_wr_ent;
        end
    end
endmodule

// ===== rtl/negb_back.sv =====
// Bookkeeping part: stores point bins, counts bins, picks the ground bin, emits flags.
module negb_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  negb_pkg::t_negb_qent i_q_ent,
    output logic                 o_q_ready,
    input  logic [4:0]           i_excl_lo,
    input  logic [4:0]           i_excl_hi,
    negb_out_if.source           o_res
);
    import negb_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SW = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state          r_state;
    logic [6:0]      r_cnt [NUM_BINS];
    logic [SW-1:0]   r_stored;
    logic [4:0]      r_scan;
    logic            r_found;
    logic [4:0]      r_chosen;
    logic [6:0]      r_best;
    logic [SW-1:0]   r_issue;
    logic            r_pend;
    logic [AW-1:0]   r_pend_idx;
    logic            r_pend_last;
    logic            r_ov;
    logic [5:0]      r_o_idx;
    logic            r_o_keep;
    logic [4:0]      r_o_bin;
    logic [6:0]      r_o_count;
    logic            r_o_last;

    logic            pop, can_store, store, clr_cnt, excl, better, move, issue;
    logic [6:0]      cur;
    logic [4:0]      rdata;

    assign o_q_ready = (r_state == ST_LOAD);
    assign pop       = (r_state == ST_LOAD) && i_q_valid;
    assign can_store = (r_stored < SW'(MAX_POINTS));
    assign store     = pop && can_store;
    assign clr_cnt   = (r_state == ST_SCAN) && (r_scan == 5'(NUM_BINS - 1));

    assign cur    = r_cnt[r_scan];
    assign excl   = (r_scan >= i_excl_lo) && (r_scan <= i_excl_hi);
    assign better = !excl && (!r_found || (cur > r_best));

    // Read data of the RAM acts as a holding stage in front of the output register.
    assign move  = r_pend && (!r_ov || o_res.ready);
    assign issue = (r_state == ST_EMIT) && (r_issue < r_stored) && (!r_pend || move);

    negb_ram #(
        .WIDTH (5),
        .DEPTH (MAX_POINTS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_stored[AW-1:0]),
        .i_wdata (i_q_ent.bin),
        .i_re    (issue),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                r_cnt[b] <= 7'd0;
            end
        end else begin
            for (int b = 0; b < NUM_BINS; b++) begin
                if (clr_cnt) begin
                    r_cnt[b] <= 7'd0;
                end else if (store && (i_q_ent.bin == 5'(b))) begin
                    r_cnt[b] <= r_cnt[b] + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_stored <= '0;
            r_scan   <= 5'd0;
            r_found  <= 1'b0;
            r_chosen <= NO_GROUND_BIN;
            r_best   <= 7'd0;
            r_issue  <= '0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (pop) begin
                        if (can_store) begin
                            r_stored <= r_stored + 1'b1;
                        end
                        if (i_q_ent.last) begin
                            r_scan   <= 5'd0;
                            r_found  <= 1'b0;
                            r_chosen <= NO_GROUND_BIN;
                            r_best   <= 7'd0;
                            r_state  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (better) begin
                        r_found  <= 1'b1;
                        r_chosen <= r_scan;
                        r_best   <= cur;
                    end
                    if (clr_cnt) begin
                        r_issue <= '0;
                        r_state <= (r_stored == '0) ? ST_LOAD : ST_EMIT;
                    end else begin
                        r_scan <= r_scan + 5'd1;
                    end
                end
                ST_EMIT: begin
                    if (issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (move && r_pend_last) begin
                        r_stored <= '0;
                        r_state  <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase

            if (issue) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end

            if (move) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_idx  <= r_issue[AW-1:0];
            r_pend_last <= (SW'(r_issue + 1'b1) == r_stored);
        end
        if (move) begin
            r_o_idx   <= 6'(r_pend_idx);
            r_o_keep  <= r_found && (rdata == r_chosen);
            r_o_bin   <= r_chosen;
            r_o_count <= r_best;
            r_o_last  <= r_pend_last;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.point_index = r_o_idx;
    assign o_res.keep        = r_o_keep;
    assign o_res.chosen_bin  = r_o_bin;
    assign o_res.bin_count   = r_o_count;
    assign o_res.last_result = r_o_last;
endmodule

// ===== rtl/normal_elevation_ground_bin_select.sv =====
// Top level of the normal elevation ground bin selector with its register port.
//
// This block files the surface normal of each point of a cloud into one of 18
// ten-degree elevation bins (elevation plus 90 degrees, so a normal pointing
// straight up lands in bin 17 and one pointing straight down in bin 0, a zero
// normal in bin 9), counts the bins, and when the point marked last arrives
// picks the most populated bin outside the excluded band [exclude_low_bin,
// exclude_high_bin], ties going to the lower index. It then delivers one keep
// flag per stored point in arrival order; if every bin is excluded the chosen
// bin reads 31 with a count of 0 and no point is kept. Points beyond
// MAX_POINTS are dropped, although a dropped point marked last still ends the
// cloud. Normals are taken at one per cycle: a ten-stage classification
// pipeline (squares, squared norm, then one boundary compare per stage) feeds
// a four-entry queue, and the bookkeeping side stores one point per cycle.
// At the end of a cloud the bookkeeping side walks the bin counters, then
// delivers one result per cycle from the bin RAM as long as the output is
// taken; during that walk and delivery no new point is stored, so the input
// stalls once the queue and pipeline are full.
// Configuration writes must happen only while no cloud is in progress.
module normal_elevation_ground_bin_select_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    negb_in_if.sink     i_pt,
    negb_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import negb_pkg::*;

    logic [4:0] r_excl_lo_bin;
    logic [4:0] r_excl_hi_bin;
    logic       cfg_wr;
    logic       reg_idx;

    logic       fq_valid, fq_ready;
    t_negb_qent fq_ent;
    logic       bq_valid, bq_ready;
    t_negb_qent bq_ent;

    // Registers sit at byte addresses 0 and 4; the word index is address bit 2.
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excl_lo_bin <= 5'd5;
            r_excl_hi_bin <= 5'd12;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_EXCL_LO: r_excl_lo_bin <= pwdata[4:0];
                REG_EXCL_HI: r_excl_hi_bin <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // The read side returns the selected register zero-extended to the bus.
    always_comb begin
        case (reg_idx)
            REG_EXCL_LO: prdata = {27'd0, r_excl_lo_bin};
            REG_EXCL_HI: prdata = {27'd0, r_excl_hi_bin};
            default:     prdata = 32'd0;
        endcase
    end

    negb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pt      (i_pt),
        .o_q_valid (fq_valid),
        .o_q_ent   (fq_ent),
        .i_q_ready (fq_ready)
    );

    negb_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .i_wr_ent   (fq_ent),
        .o_wr_ready (fq_ready),
        .o_rd_valid (bq_valid),
        .o_rd_ent   (bq_ent),
        .i_rd_ready (bq_ready)
    );

    negb_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (bq_valid),
        .i_q_ent   (bq_ent),
        .o_q_ready (bq_ready),
        .i_excl_lo (r_excl_lo_bin),
        .i_excl_hi (r_excl_hi_bin),
        .o_res     (o_res)
    );
endmodule

// ===== tb/normal_elevation_ground_bin_select_core_tb.sv =====
// Self-checking testbench of the normal elevation ground bin selector core.
`timescale 1ns / 100ps

module normal_elevation_ground_bin_select_core_tb;
    import negb_pkg::*;

    localparam int MAX_PTS       = 64;
    localparam int SETTLE_CYCLES = 40;      // pipeline, queue and bin walk, with margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 40;

    // Squared sines of 0, 10, ..., 80 degrees in unsigned Q1.14.
    localparam longint unsigned SIN2_TAB [0:8] = '{
        0, 494, 1917, 4096, 6769, 9615, 12288, 14467, 15890
    };

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               last;
    } normal_t;

    typedef struct {
        logic [5:0] index;
        logic       keep;
        logic [4:0] bin;
        logic [6:0] count;
        logic       last;
    } keep_flag_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    negb_in_if  pt_if ();
    negb_out_if res_if ();

    normal_elevation_ground_bin_select_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block's state: per-bin histogram, bin of every stored point,
    // fill level, and the excluded band.
    byte unsigned bin_hist [NUM_BINS];
    logic [4:0]   point_bin [MAX_PTS];
    int           points_held;
    logic [4:0]   excl_lo;
    logic [4:0]   excl_hi;

    // Keep flags the block still owes, oldest first.
    keep_flag_t flags_due [$];

    // When low, neither side inserts idle cycles or stalls.
    bit gaps_on;

    int normals_sent;
    int clouds_sent;
    int reg_writes;
    int flags_checked;
    int mismatches;
    int cycle_count;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Exact square of a signed 16-bit component.
    function automatic longint unsigned sq16(input logic signed [15:0] v);
        longint m;
        m = v;
        return m * m;
    endfunction

    // Counts the boundaries that the normal reaches; the count is its bin.
    // Boundaries above the horizontal need a positive z, those below are passed
    // by any non-negative z, and the horizontal itself by z >= 0.
    function automatic logic [4:0] elevation_bin(input normal_t p);
        longint unsigned z2;
        longint unsigned n2;
        longint unsigned lhs;
        int d;
        bit hit;
        logic [4:0] b;
        z2  = sq16(p.nz);
        n2  = sq16(p.nx) + sq16(p.ny) + z2;
        lhs = z2 << 14;
        b   = '0;
        for (int k = 1; k < NUM_BINS; k++) begin
            d = k - 9;
            if (d > 0) begin
                hit = (p.nz > 0) && (lhs >= SIN2_TAB[d] * n2);
            end else if (d == 0) begin
                hit = (p.nz >= 0);
            end else begin
                hit = (p.nz >= 0) || (lhs <= SIN2_TAB[-d] * n2);
            end
            if (hit) b++;
        end
        return b;
    endfunction

    // Files one accepted normal; at the end of a cloud it picks the ground bin
    // and queues one keep flag per stored point.
    function automatic void file_normal(input normal_t p);
        logic [4:0] b;
        logic [4:0] pick;
        int unsigned best;
        bit found;
        keep_flag_t f;
        if (points_held < MAX_PTS) begin
            b = elevation_bin(p);
            point_bin[points_held] = b;
            bin_hist[b]++;
            points_held++;
        end
        if (!p.last) return;
        found = 1'b0;
        pick  = NO_GROUND_BIN;
        best  = 0;
        for (int i = 0; i < NUM_BINS; i++) begin
            if (i >= excl_lo && i <= excl_hi) continue;
            // A strict compare keeps the lower index on a tie.
            if (!found || bin_hist[i] > best) begin
                found = 1'b1;
                pick  = 5'(i);
                best  = bin_hist[i];
            end
        end
        for (int i = 0; i < points_held; i++) begin
            f.index = 6'(i);
            f.keep  = found && (point_bin[i] == pick);
            f.bin   = pick;
            f.count = 7'(best);
            f.last  = (i == points_held - 1);
            flags_due = {flags_due, f};
        end
        for (int i = 0; i < NUM_BINS; i++) bin_hist[i] = 0;
        points_held = 0;
    endfunction

    function automatic normal_t mk(input int x, input int y, input int z, input bit l);
        normal_t p;
        p.nx   = 16'(x);
        p.ny   = 16'(y);
        p.nz   = 16'(z);
        p.last = l;
        return p;
    endfunction

    // Draws a normal: often close to the cloud's dominant direction so that one
    // bin wins clearly, otherwise raw 16-bit words, in-range vectors or near-axis ones.
    function automatic normal_t rand_normal(input normal_t dir);
        normal_t p;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            p = mk($urandom, $urandom, $urandom, 1'b0);
        end else if (pick < 65) begin
            p = mk(int'(dir.nx) + int'($urandom_range(4000)) - 2000,
                   int'(dir.ny) + int'($urandom_range(4000)) - 2000,
                   int'(dir.nz) + int'($urandom_range(4000)) - 2000, 1'b0);
        end else if (pick < 85) begin
            p = mk(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                   int'($urandom_range(32768)) - 16384, 1'b0);
        end else begin
            p = mk(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
                   int'($urandom_range(600)) - 300, 1'b0);
            if ($urandom_range(1)) p.nz = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            else p.nx = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        end
        return p;
    endfunction

    // Presents one normal and holds it until the transfer. Valid is left high
    // so that back-to-back items need no second assignment in one time step.
    task automatic send_normal(input normal_t p);
        while (gaps_on && $urandom_range(99) < 7) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.vec_x      <= p.nx;
        pt_if.vec_y      <= p.ny;
        pt_if.vec_z      <= p.nz;
        pt_if.last_point <= p.last;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        file_normal(p);
        normals_sent++;
        if (p.last) clouds_sent++;
    endtask

    // Sends a cloud of n random normals, the final one marked last.
    task automatic send_cloud(input int n);
        normal_t dir;
        normal_t p;
        dir = mk(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                 int'($urandom_range(32768)) - 16384, 1'b0);
        for (int i = 0; i < n; i++) begin
            p = rand_normal(dir);
            p.last = (i == n - 1);
            send_normal(p);
        end
    endtask

    // Stops sending until every owed keep flag has been transferred, then lets
    // the block settle so that it is idle for a register write.
    task automatic drain_results();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (flags_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Two-phase register write: setup, then access; the register takes the
    // value at the edge that ends the access cycle.
    task automatic write_reg(input logic idx, input logic [4:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_EXCL_LO) excl_lo = val;
        else excl_hi = val;
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_band(input logic [4:0] lo, input logic [4:0] hi);
        drain_results();
        write_reg(REG_EXCL_LO, lo);
        write_reg(REG_EXCL_HI, hi);
    endtask

    // Axis directions, the zero normal, extreme and out-of-range components,
    // and a few angles near boundaries, under the reset band.
    task automatic test_extremes();
        send_normal(mk(0, 0, 16384, 1'b0));
        send_normal(mk(0, 0, -16384, 1'b0));
        send_normal(mk(0, 0, 0, 1'b0));
        send_normal(mk(16384, 0, 0, 1'b0));
        send_normal(mk(0, -16384, 0, 1'b0));
        send_normal(mk(-32768, -32768, -32768, 1'b0));
        send_normal(mk(32767, 32767, 32767, 1'b0));
        send_normal(mk(0, 0, -32768, 1'b0));
        send_normal(mk(11585, 0, 11585, 1'b0));
        send_normal(mk(0, -11585, -11585, 1'b0));
        send_normal(mk(2845, 0, 16135, 1'b0));
        send_normal(mk(16384, -16384, 16384, 1'b0));
        send_normal(mk(0, 0, 16384, 1'b1));
    endtask

    task automatic test_special_cases();
        // A one-point cloud whose only point sits in the band: every candidate
        // bin is empty, so the lowest open bin wins with a count of zero.
        send_normal(mk(0, 0, 0, 1'b1));
        // Equal counts in bins 0 and 17: the lower index must win.
        send_normal(mk(0, 0, 16384, 1'b0));
        send_normal(mk(0, 0, 16384, 1'b0));
        send_normal(mk(0, 0, -16384, 1'b0));
        send_normal(mk(0, 0, -16384, 1'b1));
        // Band covering every bin: no ground at all.
        set_band(5'd0, 5'd17);
        send_normal(mk(0, 0, 16384, 1'b0));
        send_normal(mk(0, 0, 0, 1'b1));
        // Low above high: nothing excluded, so the flat normals in bin 9 win.
        set_band(5'd17, 5'd0);
        send_normal(mk(0, 0, 0, 1'b0));
        send_normal(mk(100, 0, 0, 1'b0));
        send_normal(mk(0, 0, 16384, 1'b1));
        // Only bin 17 open and nothing in it.
        set_band(5'd0, 5'd16);
        send_normal(mk(0, 0, 0, 1'b0));
        send_normal(mk(0, 0, 0, 1'b1));
    endtask

    // A cloud that fills the store and then overflows, ending on a dropped
    // point. It runs with no idling on either side.
    task automatic test_capacity();
        set_band(5'd5, 5'd12);
        gaps_on = 1'b0;
        send_cloud(MAX_PTS + 2);
        drain_results();
        gaps_on = 1'b1;
    endtask

    // Steps through band settings at and beyond the bin range.
    task automatic test_band_sweep();
        logic [4:0] lo_set [7] = '{5'd0, 5'd17, 5'd0, 5'd17, 5'd31, 5'd3, 5'd5};
        logic [4:0] hi_set [7] = '{5'd17, 5'd0, 5'd0, 5'd17, 5'd31, 5'd31, 5'd12};
        for (int i = 0; i < 7; i++) begin
            set_band(lo_set[i], hi_set[i]);
            send_cloud($urandom_range(6, 2));
        end
    endtask

    // Random clouds, mostly small with the odd larger one. The first part runs
    // without any idling; the band is changed at random between clouds throughout.
    task automatic test_random_clouds();
        int start;
        int n;
        start = normals_sent;
        gaps_on = 1'b0;
        while (normals_sent - start < RANDOM_ITEMS) begin
            if (normals_sent - start >= 20) gaps_on = 1'b1;
            n = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(8, 1);
            send_cloud(n);
            if ($urandom_range(4) == 0) begin
                if ($urandom_range(3) == 0) set_band(5'($urandom), 5'($urandom));
                else set_band(5'($urandom_range(17)), 5'($urandom_range(17)));
            end
        end
        gaps_on = 1'b1;
    endtask

    // Takes keep flags with random stalls and compares each with the oldest owed one.
    always @(posedge i_clk) begin : keep_flag_check
        keep_flag_t want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                flags_checked++;
                if (flags_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: keep flag for point %0d arrived with none owed", $realtime,
                                 res_if.point_index);
                end else begin
                    want = flags_due.pop_front();
                    if (res_if.point_index !== want.index || res_if.keep !== want.keep ||
                        res_if.chosen_bin !== want.bin || res_if.bin_count !== want.count ||
                        res_if.last_result !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: index/keep/bin/count/last expected %0d/%0d/%0d/%0d/%0d",
                                      " got %0d/%0d/%0d/%0d/%0d"}, $realtime,
                                     want.index, want.keep, want.bin, want.count, want.last,
                                     res_if.point_index, res_if.keep, res_if.chosen_bin,
                                     res_if.bin_count, res_if.last_result);
                    end
                end
            end
            res_if.ready <= !(gaps_on && $urandom_range(99) < 7);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d keep flags still owed.", flags_due.size());
            $display("normal_elevation_ground_bin_select_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        pt_if.valid      <= 1'b0;
        pt_if.vec_x      <= '0;
        pt_if.vec_y      <= '0;
        pt_if.vec_z      <= '0;
        pt_if.last_point <= 1'b0;
        gaps_on       = 1'b1;
        normals_sent  = 0;
        clouds_sent   = 0;
        reg_writes    = 0;
        flags_checked = 0;
        mismatches    = 0;
        cycle_count   = 0;
        for (int i = 0; i < NUM_BINS; i++) bin_hist[i] = 0;
        points_held = 0;
        excl_lo     = 5'd5;
        excl_hi     = 5'd12;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_special_cases();
        test_capacity();
        test_band_sweep();
        test_random_clouds();
        drain_results();

        $display("Covered %0d normals in %0d clouds with %0d band register writes;",
                 normals_sent, clouds_sent, reg_writes);
        $display("%0d keep flags checked, %0d mismatches.", flags_checked, mismatches);
        if (mismatches == 0) begin
            $display("normal_elevation_ground_bin_select_core_tb: done, clean");
        end else begin
            $display("normal_elevation_ground_bin_select_core_tb: done, errors");
        end
        $finish;
    end

endmodule
